// ----- hw/rtl/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// C-subset token scanner package
// Shared types, token kind codes, character codes and character classes.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int KIND_BITS  = 5;
    localparam int VALUE_BITS = 31;
    localparam int CHAR_BITS  = 8;
    localparam int KW_BITS    = 40;

    typedef logic [KIND_BITS-1:0]  t_kind;
    typedef logic [CHAR_BITS-1:0]  t_char;
    typedef logic [VALUE_BITS-1:0] t_value;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_NUM,
        MODE_IDENT
    } t_mode;

    // Token kinds
    localparam t_kind K_EOF    = 5'd0;
    localparam t_kind K_PLUS   = 5'd1;
    localparam t_kind K_MINUS  = 5'd2;
    localparam t_kind K_STAR   = 5'd3;
    localparam t_kind K_SLASH  = 5'd4;
    localparam t_kind K_LPAREN = 5'd5;
    localparam t_kind K_RPAREN = 5'd6;
    localparam t_kind K_LBRACE = 5'd7;
    localparam t_kind K_RBRACE = 5'd8;
    localparam t_kind K_SEMI   = 5'd9;
    localparam t_kind K_COMMA  = 5'd10;
    localparam t_kind K_EQ     = 5'd11;
    localparam t_kind K_ASSIGN = 5'd12;
    localparam t_kind K_NE     = 5'd13;
    localparam t_kind K_GE     = 5'd14;
    localparam t_kind K_GT     = 5'd15;
    localparam t_kind K_LE     = 5'd16;
    localparam t_kind K_LT     = 5'd17;
    localparam t_kind K_NUM    = 5'd18;
    localparam t_kind K_IDENT  = 5'd19;
    localparam t_kind K_IF     = 5'd20;
    localparam t_kind K_ELSE   = 5'd21;
    localparam t_kind K_WHILE  = 5'd22;
    localparam t_kind K_DO     = 5'd23;
    localparam t_kind K_FOR    = 5'd24;
    localparam t_kind K_ERROR  = 5'd25;

    // Character codes
    localparam t_char CH_NUL    = 8'h00;
    localparam t_char CH_TAB    = 8'h09;
    localparam t_char CH_NL     = 8'h0A;
    localparam t_char CH_CR     = 8'h0D;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_BANG   = 8'h21;
    localparam t_char CH_LPAREN = 8'h28;
    localparam t_char CH_RPAREN = 8'h29;
    localparam t_char CH_STAR   = 8'h2A;
    localparam t_char CH_PLUS   = 8'h2B;
    localparam t_char CH_COMMA  = 8'h2C;
    localparam t_char CH_MINUS  = 8'h2D;
    localparam t_char CH_SLASH  = 8'h2F;
    localparam t_char CH_0      = 8'h30;
    localparam t_char CH_9      = 8'h39;
    localparam t_char CH_SEMI   = 8'h3B;
    localparam t_char CH_LT     = 8'h3C;
    localparam t_char CH_EQ     = 8'h3D;
    localparam t_char CH_GT     = 8'h3E;
    localparam t_char CH_UC_A   = 8'h41;
    localparam t_char CH_UC_Z   = 8'h5A;
    localparam t_char CH_USCORE = 8'h5F;
    localparam t_char CH_LC_A   = 8'h61;
    localparam t_char CH_LC_Z   = 8'h7A;
    localparam t_char CH_LBRACE = 8'h7B;
    localparam t_char CH_RBRACE = 8'h7D;

    // Keywords, packed oldest byte high
    localparam logic [KW_BITS-1:0] KW_IF    = 40'h00_0000_6966;
    localparam logic [KW_BITS-1:0] KW_ELSE  = 40'h00_656C_7365;
    localparam logic [KW_BITS-1:0] KW_WHILE = 40'h77_6869_6C65;
    localparam logic [KW_BITS-1:0] KW_DO    = 40'h00_0000_646F;
    localparam logic [KW_BITS-1:0] KW_FOR   = 40'h00_0066_6F72;

    localparam t_value NUM_MAX = 31'h7FFF_FFFF;

    function automatic logic is_digit(input t_char c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input t_char c);
        return ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
               ((c >= CH_LC_A) && (c <= CH_LC_Z)) || (c == CH_USCORE);
    endfunction

    function automatic logic is_blank(input t_char c);
        return (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_op_start(input t_char c);
        return (c == CH_EQ) || (c == CH_BANG) || (c == CH_GT) || (c == CH_LT);
    endfunction

    function automatic logic is_single(input t_char c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
               (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_SEMI) ||
               (c == CH_COMMA);
    endfunction

    function automatic t_kind single_kind(input t_char c);
        t_kind k;
        unique case (c)
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_STAR:   k = K_STAR;
            CH_SLASH:  k = K_SLASH;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_SEMI:   k = K_SEMI;
            CH_COMMA:  k = K_COMMA;
            default:   k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

// ----- hw/rtl/cst_scanner.sv -----
// ----------------------------------------------------------------------------
// C-subset token scanner core
// Scan state plus one pass of next-state logic; emits up to two tokens per item.
// ----------------------------------------------------------------------------
module cst_scanner
    import cst_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12,
    localparam int TOKEN_BITS = KIND_BITS + VALUE_BITS + LINE_BITS + 2*COLUMN_BITS + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  t_char                 i_char_code,
    input  logic                  i_end_of_input,
    output logic [1:0]            o_push_count,
    output logic [TOKEN_BITS-1:0] o_token_first,
    output logic [TOKEN_BITS-1:0] o_token_second
);

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    t_mode                  r_mode,       n_mode;
    t_char                  r_first_char, n_first_char;
    t_value                 r_number,     n_number;
    logic [KW_BITS-1:0]     r_prefix,     n_prefix;
    logic [LINE_BITS-1:0]   r_line,       n_line;
    logic [COLUMN_BITS-1:0] r_col,        n_col;
    logic [COLUMN_BITS-1:0] r_start,      n_start;
    logic [COLUMN_BITS-1:0] r_count,      n_count;

    logic [COLUMN_BITS-1:0] col_inc;
    logic [COLUMN_BITS-1:0] count_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic [VALUE_BITS+3:0]  num_wide;
    t_value                 num_next;
    t_value                 digit_value;
    t_kind                  ident_kind;
    t_kind                  fl_kind;
    t_value                 fl_value;
    logic [COLUMN_BITS-1:0] fl_len;
    logic                   fl_v;
    logic                   nw_v;
    t_kind                  nw_kind;
    logic [COLUMN_BITS-1:0] nw_col;
    logic [COLUMN_BITS-1:0] nw_len;
    logic [TOKEN_BITS-1:0]  flush_token;
    logic [TOKEN_BITS-1:0]  new_token;

    assign col_inc   = (r_col == COL_MAX) ? r_col : r_col + 1'b1;
    assign count_inc = (r_count == COL_MAX) ? r_count : r_count + 1'b1;
    assign line_inc  = (r_line == LINE_MAX) ? r_line : r_line + 1'b1;

    // acc * 10 + digit, saturated
    assign digit_value = VALUE_BITS'(i_char_code - CH_0);
    assign num_wide = {1'b0, r_number, 3'b000} + {3'b000, r_number, 1'b0}
                    + {4'b0000, digit_value};
    assign num_next = (num_wide > {4'b0000, NUM_MAX}) ? NUM_MAX : num_wide[VALUE_BITS-1:0];

    always_comb begin
        if (r_count == COLUMN_BITS'(2) && r_prefix == KW_IF) begin
            ident_kind = K_IF;
        end else if (r_count == COLUMN_BITS'(4) && r_prefix == KW_ELSE) begin
            ident_kind = K_ELSE;
        end else if (r_count == COLUMN_BITS'(5) && r_prefix == KW_WHILE) begin
            ident_kind = K_WHILE;
        end else if (r_count == COLUMN_BITS'(2) && r_prefix == KW_DO) begin
            ident_kind = K_DO;
        end else if (r_count == COLUMN_BITS'(3) && r_prefix == KW_FOR) begin
            ident_kind = K_FOR;
        end else begin
            ident_kind = K_IDENT;
        end
    end

    // Pending token as it stands if nothing extends it
    always_comb begin
        fl_value = '0;
        fl_len   = r_count;
        unique case (r_mode)
            MODE_OP: begin
                fl_len = COLUMN_BITS'(1);
                if (r_first_char == CH_EQ) begin
                    fl_kind = K_ASSIGN;
                end else if (r_first_char == CH_GT) begin
                    fl_kind = K_GT;
                end else if (r_first_char == CH_LT) begin
                    fl_kind = K_LT;
                end else begin
                    fl_kind = K_ERROR;
                end
            end
            MODE_NUM: begin
                fl_kind  = K_NUM;
                fl_value = r_number;
            end
            MODE_IDENT: fl_kind = ident_kind;
            default:    fl_kind = K_EOF;
        endcase
    end

    always_comb begin
        n_mode       = r_mode;
        n_first_char = r_first_char;
        n_number     = r_number;
        n_prefix     = r_prefix;
        n_line       = r_line;
        n_col        = r_col;
        n_start      = r_start;
        n_count      = r_count;
        fl_v         = 1'b0;
        nw_v         = 1'b0;
        nw_kind      = K_EOF;
        nw_col       = r_col;
        nw_len       = COLUMN_BITS'(1);

        if (i_end_of_input) begin
            fl_v         = (r_mode != MODE_IDLE);
            nw_v         = 1'b1;
            nw_len       = '0;
            n_mode       = MODE_IDLE;
            n_first_char = '0;
            n_number     = '0;
            n_prefix     = '0;
            n_count      = '0;
        end else if (r_mode == MODE_OP && i_char_code == CH_EQ) begin
            nw_v   = 1'b1;
            nw_col = r_start;
            nw_len = COLUMN_BITS'(2);
            if (r_first_char == CH_BANG) begin
                nw_kind = K_NE;
            end else if (r_first_char == CH_GT) begin
                nw_kind = K_GE;
            end else if (r_first_char == CH_LT) begin
                nw_kind = K_LE;
            end else begin
                nw_kind = K_EQ;
            end
            n_mode       = MODE_IDLE;
            n_first_char = '0;
            n_count      = '0;
            n_col        = col_inc;
        end else if (r_mode == MODE_NUM && is_digit(i_char_code)) begin
            n_number = num_next;
            n_count  = count_inc;
            n_col    = col_inc;
        end else if (r_mode == MODE_IDENT &&
                     (is_letter(i_char_code) || is_digit(i_char_code))) begin
            // keep only the first five bytes for keyword matching
            if (r_count < COLUMN_BITS'(5)) begin
                n_prefix = {r_prefix[KW_BITS-CHAR_BITS-1:0], i_char_code};
            end
            n_count = count_inc;
            n_col   = col_inc;
        end else begin
            fl_v         = (r_mode != MODE_IDLE);
            n_mode       = MODE_IDLE;
            n_first_char = '0;
            n_number     = '0;
            n_prefix     = '0;
            n_count      = '0;
            priority if (i_char_code == CH_NL) begin
                n_line = line_inc;
                n_col  = '0;
            end else if (is_blank(i_char_code)) begin
                n_col = col_inc;
            end else if (is_single(i_char_code)) begin
                nw_v    = 1'b1;
                nw_kind = single_kind(i_char_code);
                n_col   = col_inc;
            end else if (is_op_start(i_char_code)) begin
                n_mode       = MODE_OP;
                n_first_char = i_char_code;
                n_start      = r_col;
                n_count      = COLUMN_BITS'(1);
                n_col        = col_inc;
            end else if (is_digit(i_char_code)) begin
                n_mode   = MODE_NUM;
                n_number = digit_value;
                n_start  = r_col;
                n_count  = COLUMN_BITS'(1);
                n_col    = col_inc;
            end else if (is_letter(i_char_code)) begin
                n_mode   = MODE_IDENT;
                n_prefix = KW_BITS'(i_char_code);
                n_start  = r_col;
                n_count  = COLUMN_BITS'(1);
                n_col    = col_inc;
            end else begin
                nw_v    = 1'b1;
                nw_kind = K_ERROR;
                n_col   = col_inc;
            end
        end
    end

    // Field order: kind, value, line, column, length, last
    assign flush_token = {fl_kind, fl_value, r_line, r_start, fl_len, ~nw_v};
    assign new_token   = {nw_kind, t_value'(0), r_line, nw_col, nw_len, 1'b1};

    assign o_token_first  = fl_v ? flush_token : new_token;
    assign o_token_second = new_token;
    assign o_push_count   = i_go ? ({1'b0, fl_v} + {1'b0, nw_v}) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_first_char <= '0;
            r_number     <= '0;
            r_prefix     <= '0;
            r_line       <= LINE_BITS'(1);
            r_col        <= '0;
            r_start      <= '0;
            r_count      <= '0;
        end else if (i_go) begin
            r_mode       <= n_mode;
            r_first_char <= n_first_char;
            r_number     <= n_number;
            r_prefix     <= n_prefix;
            r_line       <= n_line;
            r_col        <= n_col;
            r_start      <= n_start;
            r_count      <= n_count;
        end
    end

endmodule

// ----- hw/rtl/cst_token_fifo.sv -----
// ----------------------------------------------------------------------------
// C-subset token scanner result queue
// Small queue that takes up to two tokens per cycle and hands out one.
// ----------------------------------------------------------------------------
module cst_token_fifo
    import cst_pkg::*;
#(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = 4,
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_push_count,
    input  logic [DATA_BITS-1:0] i_data_first,
    input  logic [DATA_BITS-1:0] i_data_second,
    output logic                 o_room_for_two,
    output logic                 o_valid,
    output logic [DATA_BITS-1:0] o_data,
    input  logic                 i_ready
);

    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]  r_count,  n_count;
    logic [PTR_BITS-1:0]  wr_ptr_next;
    logic                 pop;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_next    = ptr_inc(r_wr_ptr);
    assign pop            = o_valid && i_ready;
    assign o_valid        = (r_count != '0);
    assign o_data         = r_mem[r_rd_ptr];
    assign o_room_for_two = (r_count <= CNT_BITS'(DEPTH - 2));

    always_comb begin
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        if (i_push_count == 2'd2) begin
            n_wr_ptr = ptr_inc(wr_ptr_next);
        end else if (i_push_count == 2'd1) begin
            n_wr_ptr = wr_ptr_next;
        end else begin
            n_wr_ptr = r_wr_ptr;
        end
        n_count = r_count + CNT_BITS'(i_push_count) - CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_data_first;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_ptr_next] <= i_data_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- hw/rtl/c_subset_token_scanner.sv -----
// ----------------------------------------------------------------------------
// C-subset token scanner
// Byte-stream lexer for a small C subset with a valid/ready item interface.
// ----------------------------------------------------------------------------
// Each input item is one source byte or an end-of-input mark. An item is
// registered, then scanned once the queue has room for two tokens, and its
// tokens (none, one or two) are written into a four-entry result queue; the
// head of the queue drives the output port once a token is written. The
// block accepts one item per cycle as long as the output side takes tokens;
// since the output port moves one token per cycle, an item that flushes a
// pending token and emits a new one fills two queue entries, and input ready
// drops while an item waits in the input register and the queue has fewer
// than two free entries. Numbers, identifiers and operators that may grow
// (=, !, <, >) are held until a byte arrives that ends them, so their token
// leaves with the item that follows. Line, column and length saturate at
// LINE_BITS and COLUMN_BITS all-ones.
// ----------------------------------------------------------------------------
module c_subset_token_scanner
    import cst_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_char_code,
    input  logic                   i_end_of_input,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [4:0]             o_token_kind,
    output logic [30:0]            o_number_value,
    output logic [LINE_BITS-1:0]   o_line_number,
    output logic [COLUMN_BITS-1:0] o_start_column,
    output logic [COLUMN_BITS-1:0] o_token_length,
    output logic                   o_last
);

    localparam int TOKEN_BITS = KIND_BITS + VALUE_BITS + LINE_BITS + 2*COLUMN_BITS + 1;
    localparam int QUEUE_DEPTH = 4;

    logic                  r_in_valid;
    t_char                 r_char;
    logic                  r_eoi;
    logic                  core_go;
    logic                  room_for_two;
    logic [1:0]            push_count;
    logic [TOKEN_BITS-1:0] token_first;
    logic [TOKEN_BITS-1:0] token_second;
    logic [TOKEN_BITS-1:0] token_out;

    assign core_go    = r_in_valid && room_for_two;
    assign o_in_ready = !r_in_valid || core_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (core_go) begin
            r_in_valid <= 1'b0;
        end
    end

    // hold the item until the scanner takes it
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_char <= i_char_code;
            r_eoi  <= i_end_of_input;
        end
    end

    cst_scanner #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_scanner (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (core_go),
        .i_char_code    (r_char),
        .i_end_of_input (r_eoi),
        .o_push_count   (push_count),
        .o_token_first  (token_first),
        .o_token_second (token_second)
    );

    cst_token_fifo #(
        .DATA_BITS (TOKEN_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_token_fifo (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push_count   (push_count),
        .i_data_first   (token_first),
        .i_data_second  (token_second),
        .o_room_for_two (room_for_two),
        .o_valid        (o_out_valid),
        .o_data         (token_out),
        .i_ready        (i_out_ready)
    );

    assign {o_token_kind, o_number_value, o_line_number,
            o_start_column, o_token_length, o_last} = token_out;

endmodule
